### hw/rtl/clw_pkg.sv
// Types and constants shared by the capability list walker.
package clw_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_POINTER = 2'd1,
        PH_HEADER  = 2'd2,
        PH_CONTROL = 2'd3
    } phase_t;

    localparam logic        MODE_START       = 1'b0;
    localparam logic        MODE_DATA        = 1'b1;
    localparam logic [7:0]  CAP_LIST_PTR     = 8'h34;
    localparam logic [7:0]  PM_CAP_ID        = 8'h01;
    localparam logic [7:0]  PM_CONTROL_DELTA = 8'h04;
    localparam logic [7:0]  PM_LAST_OFFSET   = 8'hf8;
    localparam logic [7:0]  LIST_LOW         = 8'h40;
    localparam logic [7:0]  LIST_HIGH        = 8'hfc;
    localparam logic [31:0] ALL_ONES         = 32'hffff_ffff;

    typedef struct packed {
        logic        mode;
        logic        caps_present;
        logic [31:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic        request_valid;
        logic [7:0]  request_address;
        logic        finished;
        logic        failed;
        logic [15:0] power_state;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  current_offset;
        logic [7:0]  pending_next;
        logic [63:0] visited_map;
        logic        power_seen;
        logic [15:0] power_word;
    } walk_state_t;

endpackage

### hw/rtl/clw_in_if.sv
// Valid/ready channel carrying walker input beats.
interface clw_in_if;
    logic              valid;
    logic              ready;
    clw_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/clw_out_if.sv
// Valid/ready channel carrying walker result beats.
interface clw_out_if;
    logic               valid;
    logic               ready;
    clw_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/capability_list_walker_top.sv
// Capability list walker top level: input register, walk step, result register.
// Takes one beat per clock while the result register is free or being taken, and gives one
// result beat per input beat, in order. A beat is held in the input register and then moves
// into the result register, where its result is presented; the walk step between them is
// combinational, compares and one visited-bitmap lookup, and the walker state is updated as
// the beat moves into the result register. A mode 0 beat starts a new walk (abandoning any
// walk in progress); each mode 1 beat returns the dword read at the previously requested
// address. No clearing pass is needed after reset.
module capability_list_walker_top (
    input  logic       clk,
    input  logic       rst_n,
    clw_in_if.sink     cmd,
    clw_out_if.source  rsp
);

    logic                  in_valid_reg;
    clw_pkg::in_item_t     in_item_reg;
    logic                  out_valid_reg;
    clw_pkg::out_item_t    out_item_reg;
    clw_pkg::walk_state_t  state_reg;
    clw_pkg::walk_state_t  state_next;
    clw_pkg::out_item_t    walk_res;
    logic                  advance;
    logic                  move;

    assign advance   = !out_valid_reg || rsp.ready;
    assign move      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    clw_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (walk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: clw_pkg::PH_IDLE, default: '0};
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg <= cmd.item;
        end
        if (move)
        begin
            out_item_reg <= walk_res;
        end
    end

    a_fail_implies_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.failed |-> out_item_reg.finished)
        else $error("failed result without finished");

    a_request_or_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.request_valid && out_item_reg.finished))
        else $error("request and finish on the same result");

    a_visited_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.visited_map[15:0] == 16'h0000)
        else $error("visited bit below the capability area");

    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        move && walk_res.finished |=> state_reg.phase == clw_pkg::PH_IDLE)
        else $error("walker not idle after end of walk");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("pending result changed while stalled");

endmodule

### hw/rtl/clw_step.sv
// Combinational walk step: next walker state and result for one input beat.
module clw_step (
    input  clw_pkg::in_item_t   item,
    input  clw_pkg::walk_state_t state,
    output clw_pkg::walk_state_t state_next,
    output clw_pkg::out_item_t  result
);

    logic        do_follow;
    logic [7:0]  follow_off;
    logic [5:0]  follow_idx;
    logic        follow_bad;
    logic [15:0] word_next;

    always_comb
    begin
        state_next = state;
        result     = '0;
        do_follow  = 1'b0;
        follow_off = '0;
        word_next  = state.power_word;

        if (item.mode == clw_pkg::MODE_START)
        begin
            state_next.current_offset = '0;
            state_next.pending_next   = '0;
            state_next.visited_map    = '0;
            state_next.power_seen     = 1'b0;
            state_next.power_word     = '0;
            if (item.caps_present)
            begin
                state_next.phase       = clw_pkg::PH_POINTER;
                result.request_valid   = 1'b1;
                result.request_address = clw_pkg::CAP_LIST_PTR;
            end
            else
            begin
                state_next.phase = clw_pkg::PH_IDLE;
                result.finished  = 1'b1;
            end
        end
        else if (state.phase == clw_pkg::PH_IDLE)
        begin
            // stray read data: all-zero result, no state change
        end
        else if (item.read_data == clw_pkg::ALL_ONES)
        begin
            state_next.phase = clw_pkg::PH_IDLE;
            result.finished  = 1'b1;
            result.failed    = 1'b1;
        end
        else
        begin
            unique case (state.phase)
                clw_pkg::PH_POINTER:
                begin
                    do_follow  = 1'b1;
                    follow_off = item.read_data[7:0];
                end
                clw_pkg::PH_HEADER:
                begin
                    if (item.read_data[7:0] == clw_pkg::PM_CAP_ID)
                    begin
                        if (state.power_seen || state.current_offset > clw_pkg::PM_LAST_OFFSET)
                        begin
                            state_next.phase = clw_pkg::PH_IDLE;
                            result.finished  = 1'b1;
                            result.failed    = 1'b1;
                        end
                        else
                        begin
                            state_next.power_seen   = 1'b1;
                            state_next.pending_next = item.read_data[15:8];
                            state_next.phase        = clw_pkg::PH_CONTROL;
                            result.request_valid    = 1'b1;
                            result.request_address  = state.current_offset
                                                      + clw_pkg::PM_CONTROL_DELTA;
                        end
                    end
                    else
                    begin
                        do_follow  = 1'b1;
                        follow_off = item.read_data[15:8];
                    end
                end
                clw_pkg::PH_CONTROL:
                begin
                    word_next             = item.read_data[15:0];
                    state_next.power_word = word_next;
                    do_follow             = 1'b1;
                    follow_off            = state.pending_next;
                end
                default:
                begin
                end
            endcase
        end

        follow_idx = follow_off[7:2];
        follow_bad = (follow_off < clw_pkg::LIST_LOW) || (follow_off > clw_pkg::LIST_HIGH)
                     || (follow_off[1:0] != 2'b00) || state.visited_map[follow_idx];

        if (do_follow)
        begin
            if (follow_off == 8'h00)
            begin
                state_next.phase   = clw_pkg::PH_IDLE;
                result.finished    = 1'b1;
                result.power_state = word_next;
            end
            else if (follow_bad)
            begin
                state_next.phase = clw_pkg::PH_IDLE;
                result.finished  = 1'b1;
                result.failed    = 1'b1;
            end
            else
            begin
                state_next.visited_map[follow_idx] = 1'b1;
                state_next.current_offset          = follow_off;
                state_next.phase                   = clw_pkg::PH_HEADER;
                result.request_valid               = 1'b1;
                result.request_address             = follow_off;
            end
        end
    end

endmodule
